// File: rtl/core/dpd_pkg.sv
// Package for the deviation persistence detector: register indexes, op codes,
// direction codes and default widths. No dependencies.
package dpd_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 16;
  localparam int FIELD_WIDTH         = 16;
  localparam int CFG_INDEX_WIDTH     = 3;
  localparam int DIR_WIDTH           = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_VALUE       = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NORMAL_MARGIN    = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_IMMEDIATE_MARGIN = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIRECTION_MODE   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RETREAT_ENABLE   = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOAD_COUNT       = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPEAT_INTERVAL  = 3'd6;

  localparam logic OP_CHECK  = 1'b0;
  localparam logic OP_RELOAD = 1'b1;

  localparam logic [DIR_WIDTH-1:0] DIR_BOTH = 2'd0;
  localparam logic [DIR_WIDTH-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_WIDTH-1:0] DIR_DOWN = 2'd2;
  localparam logic [DIR_WIDTH-1:0] DIR_NONE = 2'd3;

  typedef struct packed {
    logic [DIR_WIDTH-1:0] direction_mode;
    logic                 retreat_enable;
  } dpd_mode_t;

endpackage

// File: rtl/core/deviation_persistence_detector.sv
// Top level of the deviation persistence detector: channels, configuration
// registers, input and result registers. Depends on dpd_pkg and dpd_eval.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready with the sample in s_tdata and the
//   op in s_tuser (0 check sample, 1 reload counter from load value).
//   Each item gives exactly one result on m_tvalid/m_tready, detected in
//   m_tdata bit 0 (bit 0 is always 0 for a reload item).
//   Configuration registers are written through cfg_valid/cfg_ready with
//   cfg_index and cfg_data; cfg_ready is always high. Write only while idle.
//   Writing load_count also sets the persistence counter.
// Timing:
//   An item is registered in the input register, is evaluated and lands in the
//   result register, from which its result can be taken.
//   One item per cycle is sustained while m_tready stays high; the counter update is a single compare,
//   subtract and select between the two registers.
// Reset and stall:
//   rst clears all configuration registers, the counter and both valid flags.
//   While m_tready is low the result holds and the input register fills; then
//   s_tready drops until the result is taken.
module deviation_persistence_detector #(
  parameter int VALUE_WIDTH = dpd_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // [VALUE_WIDTH-1:0] sample_value, zero padding above
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,
  // [0] op
  input  logic [0:0]                             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // [0] detected, zero padding above
  output logic [7:0]                             m_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dpd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [VALUE_WIDTH-1:0]                 cfg_data
);

  localparam int EFF_WIDTH = (VALUE_WIDTH < dpd_pkg::FIELD_WIDTH) ?
                             VALUE_WIDTH : dpd_pkg::FIELD_WIDTH;
  localparam logic [VALUE_WIDTH-1:0] VALUE_MASK =
    {VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - EFF_WIDTH);

  logic [VALUE_WIDTH-1:0] base_value;
  logic [VALUE_WIDTH-1:0] normal_margin;
  logic [VALUE_WIDTH-1:0] immediate_margin;
  dpd_pkg::dpd_mode_t     mode;
  logic [VALUE_WIDTH-1:0] load_count;
  logic [VALUE_WIDTH-1:0] repeat_interval;
  logic [VALUE_WIDTH-1:0] persist_count;
  logic [VALUE_WIDTH-1:0] persist_count_next;

  logic                   in_valid;
  logic                   in_op;
  logic [VALUE_WIDTH-1:0] in_sample;
  logic                   out_valid;
  logic                   out_detected;
  logic                   detected_next;
  logic                   advance;
  logic [VALUE_WIDTH-1:0] cfg_value;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign cfg_value = cfg_data & VALUE_MASK;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {7'd0, out_detected};

  dpd_eval #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_eval (
    .op                 (in_op),
    .sample_value       (in_sample),
    .base_value         (base_value),
    .normal_margin      (normal_margin),
    .immediate_margin   (immediate_margin),
    .mode               (mode),
    .load_count         (load_count),
    .repeat_interval    (repeat_interval),
    .persist_count      (persist_count),
    .persist_count_next (persist_count_next),
    .detected           (detected_next)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op     <= s_tuser[0];
      in_sample <= s_tdata[VALUE_WIDTH-1:0] & VALUE_MASK;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_detected <= detected_next;
    end
  end

  // Configuration registers and persistence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      base_value       <= '0;
      normal_margin    <= '0;
      immediate_margin <= '0;
      mode             <= '0;
      load_count       <= '0;
      repeat_interval  <= '0;
      persist_count    <= '0;
    end else begin
      if (advance) begin
        persist_count <= persist_count_next;
      end
      if (cfg_valid) begin
        case (cfg_index)
          dpd_pkg::REG_BASE_VALUE:       base_value       <= cfg_value;
          dpd_pkg::REG_NORMAL_MARGIN:    normal_margin    <= cfg_value;
          dpd_pkg::REG_IMMEDIATE_MARGIN: immediate_margin <= cfg_value;
          dpd_pkg::REG_DIRECTION_MODE: begin
            mode.direction_mode <= cfg_data[dpd_pkg::DIR_WIDTH-1:0];
          end
          dpd_pkg::REG_RETREAT_ENABLE: begin
            mode.retreat_enable <= cfg_data[0];
          end
          dpd_pkg::REG_LOAD_COUNT: begin
            load_count    <= cfg_value;
            persist_count <= cfg_value;
          end
          dpd_pkg::REG_REPEAT_INTERVAL:  repeat_interval  <= cfg_value;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/core/dpd_eval.sv
// Per-item decision logic: deviation checks and persistence counter update.
// Depends on dpd_pkg.
module dpd_eval #(
  parameter int VALUE_WIDTH = dpd_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   op,
  input  logic [VALUE_WIDTH-1:0] sample_value,
  input  logic [VALUE_WIDTH-1:0] base_value,
  input  logic [VALUE_WIDTH-1:0] normal_margin,
  input  logic [VALUE_WIDTH-1:0] immediate_margin,
  input  dpd_pkg::dpd_mode_t     mode,
  input  logic [VALUE_WIDTH-1:0] load_count,
  input  logic [VALUE_WIDTH-1:0] repeat_interval,
  input  logic [VALUE_WIDTH-1:0] persist_count,
  output logic [VALUE_WIDTH-1:0] persist_count_next,
  output logic                   detected
);

  logic                   above;
  logic                   below;
  logic [VALUE_WIDTH-1:0] dist_up;
  logic [VALUE_WIDTH-1:0] dist_down;
  logic                   up_en;
  logic                   down_en;
  logic                   fast;
  logic                   slow;
  logic [VALUE_WIDTH-1:0] count_dec;

  assign above     = sample_value > base_value;
  assign below     = sample_value < base_value;
  assign dist_up   = sample_value - base_value;
  assign dist_down = base_value - sample_value;
  assign up_en     = mode.direction_mode inside {dpd_pkg::DIR_BOTH, dpd_pkg::DIR_UP};
  assign down_en   = mode.direction_mode inside {dpd_pkg::DIR_BOTH, dpd_pkg::DIR_DOWN};

  assign fast = (immediate_margin != '0) &&
                ((up_en && above && (dist_up >= immediate_margin)) ||
                 (down_en && below && (dist_down >= immediate_margin)));
  assign slow = (normal_margin != '0) &&
                ((up_en && above && (dist_up >= normal_margin)) ||
                 (down_en && below && (dist_down >= normal_margin)));

  assign count_dec = persist_count - VALUE_WIDTH'(1);

  always_comb begin
    persist_count_next = persist_count;
    detected           = 1'b0;
    if (op == dpd_pkg::OP_RELOAD) begin
      persist_count_next = load_count;
    end else if (fast) begin
      if (repeat_interval != '0) begin
        persist_count_next = repeat_interval;
      end
      detected = 1'b1;
    end else if (slow) begin
      if (persist_count != '0) begin
        if (count_dec == '0) begin
          persist_count_next = repeat_interval;
          detected           = 1'b1;
        end else begin
          persist_count_next = count_dec;
        end
      end
    end else if (mode.retreat_enable) begin
      persist_count_next = load_count;
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for deviation_persistence_detector: feeds samples and reload items
// with random gaps and stalls, predicts every detection flag and checks it.
// Depends on dpd_pkg and the detector RTL.
module testbench;
  import dpd_pkg::*;

  localparam int VW = VALUE_WIDTH_DEFAULT;
  localparam int DW = ((VW + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 135;

  typedef logic [VW-1:0] value_t;
  typedef struct packed {
    logic   op;
    value_t sample;
  } probe_t;
  typedef struct packed {
    logic   detected;
    probe_t cause;
  } verdict_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [DW-1:0]              s_tdata = '0;
  logic [0:0]                 s_tuser = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [7:0]                 m_tdata;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [VW-1:0]              cfg_data = '0;

  value_t               base_level = '0;
  value_t               slow_margin = '0;
  value_t               fast_margin = '0;
  logic [DIR_WIDTH-1:0] watch_dir = DIR_BOTH;
  logic                 retreat_on = 1'b0;
  value_t               load_level = '0;
  value_t               rearm_level = '0;
  value_t               persist_left = '0;

  probe_t   pending_probes[$];
  verdict_t verdicts_due[$];
  probe_t   taken, next_probe;
  verdict_t due_in, due_out;
  int       errors = 0;
  int       src_pct = 0;
  int       sink_pct = 0;
  int       src_gap = 0;
  int       sink_gap = 0;
  int       cycles = 0;

  deviation_persistence_detector #(.VALUE_WIDTH(VW)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic deviates(value_t s, value_t margin, logic upward);
    if (margin == '0) return 1'b0;
    if (upward) return s > base_level && (s - base_level) >= margin;
    return s < base_level && (base_level - s) >= margin;
  endfunction

  function automatic logic judge_sample(probe_t p);
    logic up_ok, down_ok, fast, slow;
    up_ok = (watch_dir == DIR_BOTH) || (watch_dir == DIR_UP);
    down_ok = (watch_dir == DIR_BOTH) || (watch_dir == DIR_DOWN);
    if (p.op == OP_RELOAD) begin
      persist_left = load_level;
      return 1'b0;
    end
    fast = (up_ok && deviates(p.sample, fast_margin, 1'b1)) ||
           (down_ok && deviates(p.sample, fast_margin, 1'b0));
    slow = (up_ok && deviates(p.sample, slow_margin, 1'b1)) ||
           (down_ok && deviates(p.sample, slow_margin, 1'b0));
    if (fast) begin
      if (rearm_level != '0) persist_left = rearm_level;
      return 1'b1;
    end
    if (slow) begin
      if (persist_left == '0) return 1'b0;
      persist_left = persist_left - 1'b1;
      if (persist_left != '0) return 1'b0;
      if (rearm_level != '0) persist_left = rearm_level;
      return 1'b1;
    end
    if (retreat_on) persist_left = load_level;
    return 1'b0;
  endfunction

  function automatic int pick_gap(int pct);
    if (pct == 0 || $urandom_range(99) >= pct) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic value_t pick_level(int top);
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return value_t'(1);
      3, 4: return value_t'($urandom_range(top));
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic void queue_probe(logic op, value_t s);
    probe_t p;
    p.op = op;
    p.sample = s;
    pending_probes.push_back(p);
  endfunction

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, value_t data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BASE_VALUE: base_level = data;
      REG_NORMAL_MARGIN: slow_margin = data;
      REG_IMMEDIATE_MARGIN: fast_margin = data;
      REG_DIRECTION_MODE: watch_dir = data[DIR_WIDTH-1:0];
      REG_RETREAT_ENABLE: retreat_on = data[0];
      REG_LOAD_COUNT: begin
        load_level = data;
        persist_left = data;
      end
      REG_REPEAT_INTERVAL: rearm_level = data;
      default: ;
    endcase
  endtask

  task automatic configure(value_t base, value_t slow, value_t fast, value_t dir,
                           value_t retreat, value_t load, value_t rearm);
    write_reg(REG_BASE_VALUE, base);
    write_reg(REG_NORMAL_MARGIN, slow);
    write_reg(REG_IMMEDIATE_MARGIN, fast);
    write_reg(REG_DIRECTION_MODE, dir);
    write_reg(REG_RETREAT_ENABLE, retreat);
    write_reg(REG_REPEAT_INTERVAL, rearm);
    write_reg(REG_LOAD_COUNT, load);
    @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    while (pending_probes.size() != 0 || s_tvalid || verdicts_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        taken.op = s_tuser[0];
        taken.sample = s_tdata[VW-1:0];
        due_in.cause = taken;
        due_in.detected = judge_sample(taken);
        verdicts_due.push_back(due_in);
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_probes.size() > 0) begin
          next_probe = pending_probes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= DW'(next_probe.sample);
          s_tuser <= next_probe.op;
          src_gap = pick_gap(src_pct);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: result with nothing expected, got %0b", $time, m_tdata[0]);
        end else begin
          due_out = verdicts_due.pop_front();
          if (m_tdata[0] !== due_out.detected) begin
            errors++;
            if (errors <= 40)
              $display("%0t: detected for op %0d sample %0d: expected %0b, got %0b",
                       $time, due_out.cause.op, due_out.cause.sample,
                       due_out.detected, m_tdata[0]);
          end
          if (m_tdata[7:1] !== '0) begin
            errors++;
            if (errors <= 40)
              $display("%0t: result padding: expected 0, got %h", $time, m_tdata[7:1]);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_gap = pick_gap(sink_pct);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int span, wide;
    logic op;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    src_pct = 20;
    sink_pct = 20;
    configure(1000, 10, 100, DIR_BOTH, 0, 3, 2);
    queue_probe(OP_RELOAD, 16'h5a5a);
    queue_probe(OP_CHECK, 1000);
    queue_probe(OP_CHECK, 1010);
    queue_probe(OP_CHECK, 990);
    queue_probe(OP_CHECK, 1005);
    queue_probe(OP_CHECK, 1011);
    queue_probe(OP_CHECK, 1100);
    queue_probe(OP_CHECK, 900);
    queue_probe(OP_CHECK, 0);
    queue_probe(OP_CHECK, 16'hffff);
    queue_probe(OP_CHECK, 989);
    queue_probe(OP_RELOAD, 0);
    settle();

    // counter pinned at zero, both margins met, retreat back to load
    configure(16'hffff, 1, 16'hffff, DIR_DOWN, 1, 1, 0);
    queue_probe(OP_CHECK, 16'hfffe);
    queue_probe(OP_CHECK, 16'hfffe);
    queue_probe(OP_CHECK, 16'hffff);
    queue_probe(OP_CHECK, 0);
    queue_probe(OP_CHECK, 16'hfffd);
    queue_probe(OP_RELOAD, 16'hffff);
    queue_probe(OP_CHECK, 65000);
    settle();

    configure(0, 16'hffff, 0, DIR_UP, 0, 16'hffff, 16'hffff);
    queue_probe(OP_CHECK, 16'hffff);
    queue_probe(OP_CHECK, 0);
    queue_probe(OP_CHECK, 16'h8000);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      src_pct = (phase % 3 == 0) ? 0 : 15 + 15 * (phase % 3);
      sink_pct = (phase % 4 == 1) ? 0 : 20 + 15 * (phase % 3);
      configure(pick_level(16'hffff), pick_level(300), pick_level(600),
                (value_t'($urandom) << DIR_WIDTH) | value_t'(phase % 4),
                (value_t'($urandom) << 1) | value_t'(phase / 4),
                pick_level(8), pick_level(6));
      span = int'(slow_margin) + int'(fast_margin) / 2 + 4;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op = ($urandom_range(19) == 0) ? OP_RELOAD : OP_CHECK;
        if ($urandom_range(4) == 0) begin
          queue_probe(op, value_t'($urandom));
        end else begin
          wide = int'(base_level) + int'($urandom_range(2 * span)) - span;
          if (wide < 0) wide = 0;
          if (wide > (1 << VW) - 1) wide = (1 << VW) - 1;
          queue_probe(op, value_t'(wide));
        end
      end
      settle();
    end

    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
